FILE: src/crc_pkg.sv
// Shared constants, codes and types for the circle raster canvas.
// Used by crc_dist and circle_raster_canvas; no dependencies.
package crc_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam int SIZE_W  = 9;
  localparam int CHAR_W  = 8;
  localparam int COORD_W = 20;
  localparam int MODE_W  = 8;
  localparam int PIXEL_W = 8;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CFGI_W  = 2;

  // signed difference wide enough for center minus pixel position
  localparam int POS_W  = (COL_W > ROW_W ? COL_W : ROW_W) + FRAC_BITS;
  localparam int DIFF_W = (COORD_W > POS_W ? COORD_W : POS_W) + 2;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 1;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FILLED  = 8'd67;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 8'd99;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_MODE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_RADIUS = 2'd2;
  localparam logic [STAT_W-1:0] ST_OUTSIDE    = 2'd3;

  localparam logic [CFGI_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_BG     = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] r;
    logic [CHAR_W-1:0]         paint;
    logic                      filled;
  } circ_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } wr_t;

endpackage

FILE: src/crc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module crc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/crc_dist.sv
// Squared-distance pipeline: decides per scanned pixel whether it is painted.
// Depends on crc_pkg.
module crc_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       setup,
  input  crc_pkg::circ_t             circ,
  input  logic                       pix_valid,
  input  logic [crc_pkg::COL_W-1:0]  pix_col,
  input  logic [crc_pkg::ROW_W-1:0]  pix_row,
  output crc_pkg::wr_t               wr,
  output logic                       busy
);

  localparam int DW = crc_pkg::DIFF_W;
  localparam int MW = crc_pkg::MAG_W;
  localparam int CW = crc_pkg::COORD_W;

  // per-draw thresholds
  logic [crc_pkg::SUM_W-1:0] outer;
  logic [crc_pkg::SUM_W-1:0] inner;
  logic                      any_inner;

  logic signed [CW:0] k;
  logic [MW-1:0]      r_mag;
  logic [MW-1:0]      k_mag;

  assign k     = $signed({circ.r[CW-1], circ.r}) - $signed((CW+1)'(1 << crc_pkg::FRAC_BITS));
  assign r_mag = MW'($unsigned(circ.r));
  assign k_mag = MW'($unsigned(k[CW-1:0]));

  always_ff @(posedge clk) begin
    if (setup) begin
      outer     <= crc_pkg::SUM_W'(r_mag * r_mag);
      any_inner <= circ.filled | k[CW];
      inner     <= k[CW] ? '0 : crc_pkg::SUM_W'(k_mag * k_mag);
    end
  end

  // stage 1: absolute differences
  logic signed [DW-1:0] dx, dy;
  logic [MW-1:0]        adx, ady;
  logic [crc_pkg::ADDR_W-1:0] a1, a2, a3;
  logic v1, v2, v3;
  logic [crc_pkg::SQ_W-1:0]  sx, sy;
  logic [crc_pkg::SUM_W-1:0] d2;

  assign dx = {{(DW-CW){circ.cx[CW-1]}}, circ.cx} - $signed(DW'(pix_col) << crc_pkg::FRAC_BITS);
  assign dy = {{(DW-CW){circ.cy[CW-1]}}, circ.cy} - $signed(DW'(pix_row) << crc_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= pix_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    adx <= dx[DW-1] ? MW'(-dx) : MW'(dx);
    ady <= dy[DW-1] ? MW'(-dy) : MW'(dy);
    a1  <= {pix_row, pix_col};
    // stage 2: squares
    sx  <= adx * adx;
    sy  <= ady * ady;
    a2  <= a1;
    // stage 3: sum
    d2  <= {1'b0, sx} + {1'b0, sy};
    a3  <= a2;
  end

  // stage 4: threshold test drives the memory write port
  assign wr.en   = v3 && (d2 <= outer) && (any_inner || (d2 > inner));
  assign wr.addr = a3;
  assign wr.data = circ.paint;
  assign busy    = v1 | v2 | v3;

endmodule

FILE: src/circle_raster_canvas.sv
// Circle raster canvas top level: request sequencer, config registers,
// canvas memory and distance pipeline. Depends on crc_pkg, crc_ram, crc_dist.
//
// One item at a time. A clear writes every canvas entry, one per cycle
// through the memory write port. A draw scans the canvas in use one pixel
// per cycle through the distance pipeline, then waits for the pipeline to
// empty. A read goes through the registered memory read. Error items and
// unused request codes go straight to the result state. The result waits in
// the sequencer while the output register still holds an untaken result.
// The next item can be taken in the cycle after the result enters the output
// register. The canvas has no reset; read it only after a clear.
module circle_raster_canvas (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] shape_code, [27:8] center_x, [47:28] center_y, [67:48] radius,
  // [75:68] paint_char, [83:76] pixel_col, [91:84] pixel_row
  input  logic [95:0] s_tdata,
  input  logic [1:0]  s_tuser,  // [1:0] req_type
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // [7:0] pixel_char
  output logic [1:0]  m_tuser,  // [1:0] status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int CW   = crc_pkg::COORD_W;
  localparam int COLW = crc_pkg::COL_W;
  localparam int ROWW = crc_pkg::ROW_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_SETUP = 7'b0000100,
    S_DRAW  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // input fields
  logic [crc_pkg::REQ_W-1:0]   req_type;
  logic [crc_pkg::MODE_W-1:0]  shape_code;
  logic signed [CW-1:0]        center_x, center_y, radius;
  logic [crc_pkg::CHAR_W-1:0]  paint_char;
  logic [crc_pkg::PIXEL_W-1:0] pixel_col, pixel_row;

  assign req_type   = s_tuser;
  assign shape_code = s_tdata[7:0];
  assign center_x   = s_tdata[27:8];
  assign center_y   = s_tdata[47:28];
  assign radius     = s_tdata[67:48];
  assign paint_char = s_tdata[75:68];
  assign pixel_col  = s_tdata[83:76];
  assign pixel_row  = s_tdata[91:84];

  // configuration
  logic [crc_pkg::SIZE_W-1:0] canvas_width, canvas_height;
  logic [crc_pkg::CHAR_W-1:0] background_char;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= 9'd256;
      canvas_height   <= 9'd256;
      background_char <= 8'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crc_pkg::CFG_WIDTH:  canvas_width    <= cfg_data;
        crc_pkg::CFG_HEIGHT: canvas_height   <= cfg_data;
        crc_pkg::CFG_BG:     background_char <= cfg_data[crc_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes in use: zero acts as one, oversize acts as the maximum
  logic [COLW:0] w_eff;
  logic [ROWW:0] h_eff;

  always_comb begin
    if (canvas_width == '0) begin
      w_eff = (COLW+1)'(1);
    end else if (int'(canvas_width) > crc_pkg::MAX_WIDTH) begin
      w_eff = (COLW+1)'(crc_pkg::MAX_WIDTH);
    end else begin
      w_eff = (COLW+1)'(canvas_width);
    end
    if (canvas_height == '0) begin
      h_eff = (ROWW+1)'(1);
    end else if (int'(canvas_height) > crc_pkg::MAX_HEIGHT) begin
      h_eff = (ROWW+1)'(crc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = (ROWW+1)'(canvas_height);
    end
  end

  // working registers
  crc_pkg::circ_t              circ;
  logic [COLW-1:0]             scan_col;
  logic [ROWW-1:0]             scan_row;
  logic [crc_pkg::ADDR_W-1:0]  clr_addr;
  logic [crc_pkg::STAT_W-1:0]  res_status;
  logic [crc_pkg::CHAR_W-1:0]  res_pix;

  logic accept, outside, last_col, last_row, out_free;
  logic bad_mode, bad_radius;
  crc_pkg::wr_t draw_wr, mem_wr;
  logic dist_busy;
  logic [crc_pkg::CHAR_W-1:0] rdata;
  logic [crc_pkg::ADDR_W-1:0] raddr;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid & s_tready;
  assign outside    = (int'(pixel_col) >= int'(w_eff)) || (int'(pixel_row) >= int'(h_eff));
  assign bad_mode   = (shape_code != crc_pkg::MODE_FILLED) &&
                      (shape_code != crc_pkg::MODE_OUTLINE);
  assign bad_radius = radius[CW-1] || (radius == '0);
  assign last_col   = ({1'b0, scan_col} == w_eff - 1'b1);
  assign last_row   = ({1'b0, scan_row} == h_eff - 1'b1);
  assign out_free   = !m_tvalid || m_tready;
  assign raddr      = {ROWW'(pixel_row), COLW'(pixel_col)};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            crc_pkg::REQ_CLEAR: state_next = S_CLEAR;
            crc_pkg::REQ_DRAW:  state_next = (bad_mode || bad_radius) ? S_DONE : S_SETUP;
            crc_pkg::REQ_READ:  state_next = outside ? S_DONE : S_READ;
            default:            state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: if (&clr_addr) state_next = S_DONE;
      S_SETUP: state_next = S_DRAW;
      S_DRAW:  if (last_col && last_row) state_next = S_DRAIN;
      S_DRAIN: if (!dist_busy) state_next = S_DONE;
      S_READ:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_col <= '0;
      scan_row <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DRAW) begin
        if (last_col) begin
          scan_col <= '0;
          scan_row <= last_row ? '0 : scan_row + 1'b1;
        end else begin
          scan_col <= scan_col + 1'b1;
        end
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_pix    <= '0;
      res_status <= crc_pkg::ST_OK;
      clr_addr   <= '0;
      circ.cx     <= center_x;
      circ.cy     <= center_y;
      circ.r      <= radius;
      circ.paint  <= paint_char;
      circ.filled <= (shape_code == crc_pkg::MODE_FILLED);
      if (req_type == crc_pkg::REQ_DRAW) begin
        if (bad_mode) begin
          res_status <= crc_pkg::ST_BAD_MODE;
        end else if (bad_radius) begin
          res_status <= crc_pkg::ST_BAD_RADIUS;
        end
      end else if (req_type == crc_pkg::REQ_READ && outside) begin
        res_status <= crc_pkg::ST_OUTSIDE;
      end
    end
    if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
    if (state == S_READ) begin
      res_pix <= rdata;
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= res_pix;
      m_tuser <= res_status;
    end
  end

  crc_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .setup     (state == S_SETUP),
    .circ      (circ),
    .pix_valid (state == S_DRAW),
    .pix_col   (scan_col),
    .pix_row   (scan_row),
    .wr        (draw_wr),
    .busy      (dist_busy)
  );

  always_comb begin
    if (state == S_CLEAR) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = clr_addr;
      mem_wr.data = background_char;
    end else begin
      mem_wr = draw_wr;
    end
  end

  crc_ram #(
    .WIDTH (crc_pkg::CHAR_W),
    .DEPTH (crc_pkg::DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (mem_wr.en),
    .waddr (mem_wr.addr),
    .wdata (mem_wr.data),
    .re    (accept && (req_type == crc_pkg::REQ_READ)),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: test/tb_circle_raster_canvas.sv
// Testbench for circle_raster_canvas: directed table, then random phases over
// several sizes, each result checked against a typed value or a shadow model.
// Depends on crc_pkg and the circle_raster_canvas RTL; no files or arguments.
`timescale 1ns / 100ps

module tb_circle_raster_canvas;
  import crc_pkg::*;

  localparam logic [REQ_W-1:0]  REQ_SPARE = 2'd3;  // unused request code
  localparam logic [CFGI_W-1:0] CFG_NONE  = 2'd3;  // no register behind it

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic [MODE_W-1:0]         shape;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] r;
    logic [CHAR_W-1:0]         paint;
    logic [7:0]                col;
    logic [7:0]                row;
  } canvas_req_t;

  typedef struct {
    logic [STAT_W-1:0] st;
    logic [CHAR_W-1:0] pc;
  } canvas_result_t;

  typedef struct {
    bit                is_cfg;
    logic [CFGI_W-1:0] cfg_idx;
    logic [SIZE_W-1:0] cfg_val;
    canvas_req_t       it;
    bit                typed;
    logic [STAT_W-1:0] st;
    logic [CHAR_W-1:0] pc;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  circle_raster_canvas u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block
  logic [CHAR_W-1:0] shadow_canvas [DEPTH];
  logic [SIZE_W-1:0] shadow_width  = 9'd256;
  logic [SIZE_W-1:0] shadow_height = 9'd256;
  logic [CHAR_W-1:0] shadow_bg     = 8'd32;

  canvas_result_t pending_results [$];
  directed_row_t  directed_rows [$];
  bit steady = 1'b0;
  int mismatches = 0;
  int n_results = 0;
  int n_clears = 0, n_draws = 0, n_reads = 0, n_other = 0;

  function automatic int unsigned active_size(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return 32'(v);
  endfunction

  function automatic logic [95:0] pack_req(canvas_req_t it);
    return {4'b0, it.row, it.col, it.paint, it.r, it.cy, it.cx, it.shape};
  endfunction

  task automatic apply_canvas_item(input canvas_req_t it, output logic [STAT_W-1:0] st,
                                   output logic [CHAR_W-1:0] pc);
    longint cx, cy, r, k, outer, inner, d2, dx, dy, dy2;
    int unsigned w, h;
    bit whole_disc;
    w = active_size(shadow_width);
    h = active_size(shadow_height);
    st = ST_OK;
    pc = '0;
    case (it.req)
      REQ_CLEAR: foreach (shadow_canvas[i]) shadow_canvas[i] = shadow_bg;
      REQ_DRAW: begin
        cx = longint'(it.cx);
        cy = longint'(it.cy);
        r = longint'(it.r);
        if (it.shape != MODE_FILLED && it.shape != MODE_OUTLINE) st = ST_BAD_MODE;
        else if (r <= 0) st = ST_BAD_RADIUS;
        else begin
          outer = r * r;
          k = r - (longint'(1) << FRAC_BITS);
          // an outline thinner than one pixel fills the disc
          whole_disc = (it.shape == MODE_FILLED) || (k < 0);
          inner = (k < 0) ? 0 : k * k;
          for (int y = 0; y < h; y++) begin
            dy = cy - (longint'(y) << FRAC_BITS);
            dy2 = dy * dy;
            for (int x = 0; x < w; x++) begin
              dx = cx - (longint'(x) << FRAC_BITS);
              d2 = dx * dx + dy2;
              if (d2 <= outer && (whole_disc || d2 > inner))
                shadow_canvas[y * MAX_WIDTH + x] = it.paint;
            end
          end
        end
      end
      REQ_READ: begin
        if (it.col >= w || it.row >= h) st = ST_OUTSIDE;
        else pc = shadow_canvas[int'(it.row) * MAX_WIDTH + int'(it.col)];
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %0h want %0h at result %0d", what, got, want, n_results);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    canvas_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.st) report_mismatch("status field", 8'(m_tuser), 8'(want.st));
        if (m_tdata !== want.pc) report_mismatch("pixel_char", m_tdata, want.pc);
      end
    end
  end

  always @(posedge clk) m_tready <= steady || ($urandom_range(0, 99) >= 28);

  task automatic send_item(input canvas_req_t it, input bit typed,
                           input logic [STAT_W-1:0] st, input logic [CHAR_W-1:0] pc);
    canvas_result_t res;
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 28) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_req(it);
    s_tuser <= it.req;
    do @(posedge clk); while (!s_tready);
    apply_canvas_item(it, res.st, res.pc);
    if (typed) begin
      res.st = st;
      res.pc = pc;
    end
    pending_results.push_back(res);
    case (it.req)
      REQ_CLEAR: n_clears++;
      REQ_DRAW:  n_draws++;
      REQ_READ:  n_reads++;
      default:   n_other++;
    endcase
  endtask

  // stop sending and let the block run dry
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFGI_W-1:0] idx, input logic [SIZE_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:  shadow_width = val;
      CFG_HEIGHT: shadow_height = val;
      CFG_BG:     shadow_bg = val[CHAR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic canvas_req_t random_req(int unsigned w, int unsigned h,
                                             int unsigned draw_pct);
    canvas_req_t it;
    int unsigned p;
    it.req = REQ_W'($urandom);
    it.shape = MODE_W'($urandom);
    it.cx = COORD_W'($urandom);
    it.cy = COORD_W'($urandom);
    it.r = COORD_W'($urandom);
    it.paint = CHAR_W'($urandom);
    it.col = 8'($urandom);
    it.row = 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 6) begin
      // noise: unused code, or a draw with raw shape and radius
      it.req = $urandom_range(0, 1) ? REQ_SPARE : REQ_DRAW;
    end else if (p < 6 + draw_pct) begin
      it.req = REQ_DRAW;
      if ($urandom_range(0, 9) != 0)
        it.shape = $urandom_range(0, 1) ? MODE_FILLED : MODE_OUTLINE;
      if ($urandom_range(0, 9) != 0) begin
        it.cx = COORD_W'($urandom_range(0, (w + 6) * 256) - 768);
        it.cy = COORD_W'($urandom_range(0, (h + 6) * 256) - 768);
      end
      case ($urandom_range(0, 19))
        0: ;
        1, 2: it.r = COORD_W'($urandom_range(1, 255));
        default: it.r = COORD_W'($urandom_range(1, (w > h ? w : h) * 160 + 512));
      endcase
    end else begin
      it.req = REQ_READ;
      if ($urandom_range(0, 9) != 0) begin
        it.col = 8'($urandom_range(0, w < 255 ? w : 255));
        it.row = 8'($urandom_range(0, h < 255 ? h : 255));
      end
    end
    return it;
  endfunction

  function automatic canvas_req_t clear_req();
    canvas_req_t it;
    it = random_req(8, 8, 0);
    it.req = REQ_CLEAR;
    return it;
  endfunction

  task automatic run_phase(input int n, input int unsigned draw_pct, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      send_item(random_req(active_size(shadow_width), active_size(shadow_height), draw_pct),
                1'b0, ST_OK, 8'h00);
    end
  endtask

  function automatic directed_row_t d_item(logic [REQ_W-1:0] req, logic [MODE_W-1:0] shape,
                                           int cx, int cy, int r, logic [7:0] paint,
                                           logic [7:0] col, logic [7:0] row, bit typed,
                                           logic [STAT_W-1:0] st, logic [CHAR_W-1:0] pc);
    directed_row_t d;
    d.is_cfg = 1'b0;
    d.cfg_idx = '0;
    d.cfg_val = '0;
    d.it.req = req;
    d.it.shape = shape;
    d.it.cx = COORD_W'(cx);
    d.it.cy = COORD_W'(cy);
    d.it.r = COORD_W'(r);
    d.it.paint = paint;
    d.it.col = col;
    d.it.row = row;
    d.typed = typed;
    d.st = st;
    d.pc = pc;
    return d;
  endfunction

  function automatic directed_row_t d_cfg(logic [CFGI_W-1:0] idx, logic [SIZE_W-1:0] val);
    directed_row_t d;
    d = d_item(REQ_SPARE, 0, 0, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0);
    d.is_cfg = 1'b1;
    d.cfg_idx = idx;
    d.cfg_val = val;
    return d;
  endfunction

  initial begin
    // errors and the unused code first: none of them touches the canvas
    directed_rows.push_back(d_item(REQ_SPARE, 8'hFF, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF,
                                   1, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_DRAW, 8'h00, 0, 0, 256, 8'h00, 0, 0,
                                   1, ST_BAD_MODE, 8'h00));
    // bad mode wins over bad radius
    directed_rows.push_back(d_item(REQ_DRAW, 8'd100, 0, 0, -524288, 8'h55, 0, 0,
                                   1, ST_BAD_MODE, 8'h00));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_FILLED, 0, 0, 0, 8'h55, 0, 0,
                                   1, ST_BAD_RADIUS, 8'h00));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_OUTLINE, 0, 0, -1, 8'h55, 0, 0,
                                   1, ST_BAD_RADIUS, 8'h00));
    directed_rows.push_back(d_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 255, 255, 1, ST_OK, 8'd32));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 1, ST_OK, 8'd32));
    directed_rows.push_back(d_cfg(CFG_HEIGHT, 9'd32));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_FILLED, 10 * 256, 5 * 256, 3 * 256,
                                   8'h2A, 0, 0, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 10, 5, 1, ST_OK, 8'h2A));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 13, 5, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 14, 5, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_OUTLINE, 100 * 256 + 128, 10 * 256 + 64,
                                   6 * 256, 8'h6F, 0, 0, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 100, 16, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 100, 10, 0, ST_OK, 8'h00));
    // outline thinner than a pixel
    directed_rows.push_back(d_item(REQ_DRAW, MODE_OUTLINE, 200 * 256, 20 * 256, 128,
                                   8'h01, 0, 0, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 200, 20, 1, ST_OK, 8'h01));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_FILLED, -524288, -524288, 1, 8'hFF,
                                   0, 0, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_FILLED, 0, 0, 524287, 8'hFF, 0, 0,
                                   0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_DRAW, MODE_OUTLINE, 524287, 524287, 524287, 8'h00,
                                   0, 0, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 255, 31, 0, ST_OK, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 255, 32, 1, ST_OUTSIDE, 8'h00));
    directed_rows.push_back(d_item(REQ_READ, 0, 0, 0, 0, 0, 0, 255, 1, ST_OUTSIDE, 8'h00));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        cfg_write(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
      else
        send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].st,
                  directed_rows[i].pc);
    end

    // one column, height register past the top
    cfg_write(CFG_WIDTH, 9'd0);
    cfg_write(CFG_HEIGHT, 9'd511);
    cfg_write(CFG_BG, 9'd255);
    send_item(clear_req(), 1'b0, ST_OK, 8'h00);
    run_phase(18, 40, -1);

    // one row, no idling on either side
    steady <= 1'b1;
    cfg_write(CFG_WIDTH, 9'd511);
    cfg_write(CFG_HEIGHT, 9'd0);
    cfg_write(CFG_BG, 9'd0);
    send_item(clear_req(), 1'b0, ST_OK, 8'h00);
    run_phase(18, 40, -1);
    steady <= 1'b0;

    cfg_write(CFG_WIDTH, SIZE_W'($urandom_range(1, 20)));
    cfg_write(CFG_HEIGHT, SIZE_W'($urandom_range(1, 20)));
    cfg_write(CFG_BG, SIZE_W'($urandom_range(0, 255)));
    send_item(clear_req(), 1'b0, ST_OK, 8'h00);
    run_phase(20, 45, 10);

    cfg_write(CFG_NONE, SIZE_W'($urandom));
    cfg_write(CFG_WIDTH, SIZE_W'($urandom_range(1, 48)));
    cfg_write(CFG_HEIGHT, SIZE_W'($urandom_range(1, 48)));
    cfg_write(CFG_BG, SIZE_W'($urandom_range(0, 255)));
    run_phase(20, 40, -1);

    // full canvas again; draws here cost a whole scan, so keep them few
    cfg_write(CFG_WIDTH, 9'd256);
    cfg_write(CFG_HEIGHT, 9'd256);
    cfg_write(CFG_BG, 9'd32);
    run_phase(10, 20, -1);

    drain();
    $display("covered %0d clears, %0d draws, %0d reads, %0d unused codes", n_clears,
             n_draws, n_reads, n_other);
    $display("over six canvas settings; %0d results checked, %0d mismatches", n_results,
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout with %0d results still pending", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
